### hdl/fspa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_pkg: shared definitions for the slot pool allocator
// Sizes, request codes, link memory entry and the structs passed between
// the controller, the link RAM and the top level.
// ----------------------------------------------------------------------------
package fspa_pkg;

    localparam int POOL_DEPTH   = 128;
    localparam int HANDLE_W     = 7;
    localparam int HANDLE_SPACE = 1 << HANDLE_W;
    // capacity saturates at the handle space
    localparam int CAP          = (POOL_DEPTH < HANDLE_SPACE) ? POOL_DEPTH : HANDLE_SPACE;
    localparam int BUMP_W       = $clog2(HANDLE_SPACE + 1);
    localparam logic [BUMP_W-1:0] CAP_LIMIT = BUMP_W'(CAP);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [HANDLE_W-1:0] t_handle;

    typedef struct packed {
        logic    valid;
        t_handle next;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    typedef struct packed {
        logic    we;
        t_handle waddr;
        t_link   wdata;
        logic    re;
        t_handle raddr;
    } t_ram_req;

    typedef struct packed {
        logic    ok;
        t_handle slot;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

endpackage : fspa_pkg
`default_nettype wire

### hdl/fspa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_link_ram: free-list link memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fspa_link_ram (
    input  wire                 i_clk,
    input  fspa_pkg::t_ram_req  i_req,
    output fspa_pkg::t_link     o_rdata
);
    import fspa_pkg::*;

    logic [LINK_W-1:0] mem [HANDLE_SPACE];
    logic [LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = t_link'(r_rdata);

endmodule : fspa_link_ram
`default_nettype wire

### hdl/fspa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_ctrl: allocator controller
// Holds the free-list head and bump counter, drives the link RAM and
// produces one result per request. A pop waits in ST_POP for the link.
// ----------------------------------------------------------------------------
module fspa_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    input  wire                 i_func,
    input  fspa_pkg::t_handle   i_handle,
    input  fspa_pkg::t_link     i_rdata,
    output fspa_pkg::t_ram_req  o_ram_req,
    output logic                o_busy,
    output logic                o_res_valid,
    output fspa_pkg::t_result   o_res
);
    import fspa_pkg::*;

    t_state            r_state, n_state;
    t_handle           r_free_head, n_free_head;
    logic              r_free_nonempty, n_free_nonempty;
    logic [BUMP_W-1:0] r_bump_count, n_bump_count;

    logic w_can_bump;
    assign w_can_bump = (r_bump_count < CAP_LIMIT);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && (i_func == FUNC_ALLOC) && r_free_nonempty) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_ram_req       = '0;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_busy          = 1'b0;
        n_free_head     = r_free_head;
        n_free_nonempty = r_free_nonempty;
        n_bump_count    = r_bump_count;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_func == FUNC_FREE) begin
                        // push: link the handle in front of the old head
                        o_ram_req.we          = 1'b1;
                        o_ram_req.waddr       = i_handle;
                        o_ram_req.wdata.next  = r_free_head;
                        o_ram_req.wdata.valid = r_free_nonempty;
                        n_free_head           = i_handle;
                        n_free_nonempty       = 1'b1;
                        o_res_valid           = 1'b1;
                        o_res.ok              = 1'b1;
                    end else if (r_free_nonempty) begin
                        // pop: fetch the link of the head
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_free_head;
                    end else if (w_can_bump) begin
                        o_res_valid  = 1'b1;
                        o_res.ok     = 1'b1;
                        o_res.slot   = r_bump_count[HANDLE_W-1:0];
                        n_bump_count = r_bump_count + BUMP_W'(1);
                    end else begin
                        // pool exhausted
                        o_res_valid = 1'b1;
                    end
                end
            end
            ST_POP: begin
                o_busy          = 1'b1;
                o_res_valid     = 1'b1;
                o_res.ok        = 1'b1;
                o_res.slot      = r_free_head;
                n_free_head     = i_rdata.next;
                n_free_nonempty = i_rdata.valid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_free_head     <= '0;
            r_free_nonempty <= 1'b0;
            r_bump_count    <= '0;
        end else begin
            r_state         <= n_state;
            r_free_head     <= n_free_head;
            r_free_nonempty <= n_free_nonempty;
            r_bump_count    <= n_bump_count;
        end
    end

    a_bump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump_count <= CAP_LIMIT)
        else $error("bump counter beyond capacity");

    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_state == ST_IDLE))
        else $error("pop wait longer than one cycle");

    a_read_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.re |-> (!o_res_valid && !o_ram_req.we))
        else $error("link read issued together with a result or write");

    a_pop_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.re |=> (r_state == ST_POP))
        else $error("link read not followed by pop completion");

endmodule : fspa_ctrl
`default_nettype wire

### hdl/fixed_slot_pool_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_core: fixed-size slot pool allocator
// Free list threaded through a link RAM, with a bump pointer for slots
// never used before. One result transaction per request transaction.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   i_s_axis_tvalid/o_..tready   tdata: handle; tuser: func
//  m_axis    out  o_m_axis_tvalid/i_..tready   tdata: slot;   tuser: ok
//
//  Free and bump allocate answer from the controller directly; allocate from
//  the free list answers from ST_POP, once the registered link RAM read has
//  fed the new head back. Results queue in a two-entry output buffer, so
//  requests are taken while a result waits downstream. Reset is synchronous,
//  active low; the link RAM needs no clearing pass (an entry is always
//  pushed before it is popped). A full buffer stalls the request side.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [6:0] handle, [7] zero fill
    input  wire  [0:0] i_s_axis_tuser,   // [0] func
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] slot, [7] zero fill
    output logic [0:0] o_m_axis_tuser    // [0] ok
);
    import fspa_pkg::*;

    t_ram_req w_ram_req;
    t_link    w_rdata;
    logic     w_busy;
    logic     w_res_valid;
    t_result  w_res;
    logic     w_accept;

    // two-entry result buffer
    t_result    r_buf [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_drain;

    // take a request only when the controller is idle and a result slot is free
    assign o_s_axis_tready = !w_busy && (r_count != 2'd2);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_drain         = o_m_axis_tvalid && i_m_axis_tready;

    fspa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_accept),
        .i_func      (i_s_axis_tuser[0]),
        .i_handle    (i_s_axis_tdata[HANDLE_W-1:0]),
        .i_rdata     (w_rdata),
        .o_ram_req   (w_ram_req),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fspa_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    // hold results until the downstream side takes them
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_buf[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_res_valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_drain) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_res_valid} - {1'b0, w_drain};
        end
    end

    assign o_m_axis_tvalid = (r_count != 2'd0);
    assign o_m_axis_tdata  = {1'b0, r_buf[r_rd_ptr].slot};
    assign o_m_axis_tuser  = r_buf[r_rd_ptr].ok;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer overflow");

    a_room_for_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_count != 2'd2))
        else $error("result produced with no room in buffer");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> (r_count != 2'd0))
        else $error("result lost from buffer");

endmodule : fixed_slot_pool_allocator_core
`default_nettype wire
